FILE: src/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`endif

FILE: src/plsc_pkg.sv
package plsc_pkg;
    localparam int NUM_POINTS_DEF = 3;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ADC_W   = 16;
    localparam int NORM_W  = 17;
    localparam int DGAIN_W = 26;
    localparam int VGAIN_W = 20;
    localparam int DEPTH_W = 27;
    localparam int VOL_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;
    localparam int DIST_W = 17;
    localparam int QUO_W  = 34;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_BELOW = 2'd1,
        ST_ABOVE = 2'd2,
        ST_RDERR = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        R_ADC0 = 3'd0, R_ADC1 = 3'd1, R_ADC2 = 3'd2,
        R_NRM0 = 3'd3, R_NRM1 = 3'd4, R_NRM2 = 3'd5,
        R_DGAIN = 3'd6, R_VGAIN = 3'd7
    } reg_idx_t;

    // Classified word handed from front to back.
    typedef struct packed {
        status_t           status;
        logic              hit;
        logic              zero_span;
        logic              neg;
        logic [NORM_W-1:0] base;
        logic [NORM_W-1:0] mag;
        logic [DIST_W-1:0] delta;
        logic [DIST_W-1:0] span;
    } job_t;
endpackage

FILE: src/plsc_front.sv
module plsc_front #(
    parameter int NUM_POINTS = plsc_pkg::NUM_POINTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [plsc_pkg::ADC_W-1:0]   sample,
    input  logic [plsc_pkg::ADC_W-1:0]   adc_pt [3],
    input  logic [plsc_pkg::NORM_W-1:0]  norm_pt [3],
    output logic                         job_valid,
    input  logic                         job_ready,
    output plsc_pkg::job_t               job
);
    localparam int LAST = NUM_POINTS - 1;
    localparam int QD = 2;

    plsc_pkg::job_t q_reg [QD];
    plsc_pkg::job_t q_next_word;
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic signed [17:0] s, lo0, hi0, hi1, lastp;
    logic in0, in1, push, pop;

    always_comb begin
        s   = {{2{sample[plsc_pkg::ADC_W-1]}}, sample};
        lo0 = {2'b00, adc_pt[0]};
        hi0 = {2'b00, adc_pt[1]};
        hi1 = {2'b00, adc_pt[2]};
        lastp = (LAST == 1) ? hi0 : hi1;
        in0 = (s >= lo0) && (s <= hi0);
        in1 = (LAST > 1) && (s >= hi0) && (s <= hi1);
        q_next_word = '0;
        if (sample == {1'b1, {(plsc_pkg::ADC_W-1){1'b0}}}) begin
            q_next_word.status = plsc_pkg::ST_RDERR;
        end else if (s < lo0) begin
            q_next_word.status = plsc_pkg::ST_BELOW;
        end else if (s > lastp) begin
            q_next_word.status = plsc_pkg::ST_ABOVE;
        end else begin
            q_next_word.status = plsc_pkg::ST_VALID;
            if (in0 || in1) begin
                q_next_word.hit = 1'b1;
                if (in0) begin
                    q_next_word.base = norm_pt[0];
                    q_next_word.neg  = norm_pt[1] < norm_pt[0];
                    q_next_word.mag  = q_next_word.neg ? norm_pt[0] - norm_pt[1]
                                                       : norm_pt[1] - norm_pt[0];
                    q_next_word.delta = 17'(s - lo0);
                    q_next_word.span  = 17'(hi0 - lo0);
                end else begin
                    q_next_word.base = norm_pt[1];
                    q_next_word.neg  = norm_pt[2] < norm_pt[1];
                    q_next_word.mag  = q_next_word.neg ? norm_pt[1] - norm_pt[2]
                                                       : norm_pt[2] - norm_pt[1];
                    q_next_word.delta = 17'(s - hi0);
                    q_next_word.span  = 17'(hi1 - hi0);
                end
                q_next_word.zero_span = (q_next_word.span == '0);
            end
        end
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = job_valid && job_ready;

    always_comb begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
        end
        if (push) q_reg[wp_reg] <= q_next_word;
    end
endmodule

FILE: src/plsc_back.sv
module plsc_back #(
    parameter int FRAC_BITS = plsc_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  plsc_pkg::job_t                job,
    input  logic [plsc_pkg::DGAIN_W-1:0]  depth_gain,
    input  logic [plsc_pkg::VGAIN_W-1:0]  volume_gain,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    out_status,
    output logic [plsc_pkg::NORM_W-1:0]   out_norm,
    output logic [plsc_pkg::DEPTH_W-1:0]  out_depth,
    output logic [plsc_pkg::VOL_W-1:0]    out_vol
);
    localparam int DW = plsc_pkg::DIST_W;
    localparam int QW = plsc_pkg::QUO_W;
    localparam int NW = plsc_pkg::NORM_W;
    localparam int DIVS = QW;
    localparam int NST = DIVS + 6;
    localparam logic [33:0] OFFSET = 34'(((64'd298 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        plsc_pkg::status_t status;
        logic           hit;
        logic           zero_span;
        logic           neg;
        logic [NW-1:0]  base;
        logic [QW-1:0]  num;
        logic [QW-1:0]  quo;
        logic [DW:0]    rem;
        logic [DW-1:0]  span;
        logic [NW-1:0]  norm;
        logic [43:0]    dprod;
        logic [plsc_pkg::DEPTH_W-1:0] depth;
        logic [46:0]    vprod;
        logic [plsc_pkg::VOL_W-1:0] vol;
    } pipe_t;

    pipe_t p_reg [NST];
    pipe_t p_next [NST];
    logic  v_reg [NST];
    logic  go;

    // Stages stall together; the last slot is the output register.
    assign go        = !v_reg[NST-1] || out_ready;
    assign job_ready = go;

    always_comb begin
        p_next[0] = '0;
        p_next[0].status = job.status;
        p_next[0].hit = job.hit;
        p_next[0].zero_span = job.zero_span;
        p_next[0].neg = job.neg;
        p_next[0].base = job.base;
        p_next[0].span = job.span;
        p_next[0].num = QW'(job.mag) * QW'(job.delta) + QW'(job.span >> 1);
        for (int k = 1; k <= DIVS; k++) begin
            logic [DW:0] r;
            r = {p_reg[k-1].rem[DW-1:0], p_reg[k-1].num[QW-k]};
            p_next[k] = p_reg[k-1];
            if (r >= {1'b0, p_reg[k-1].span}) begin
                p_next[k].rem = r - {1'b0, p_reg[k-1].span};
                p_next[k].quo[QW-k] = 1'b1;
            end else begin
                p_next[k].rem = r;
            end
        end
        p_next[DIVS+1] = p_reg[DIVS];
        begin
            logic signed [QW+1:0] r2;
            r2 = p_reg[DIVS].neg ? $signed({2'b00, 17'(0), p_reg[DIVS].base})
                                   - $signed({2'b00, p_reg[DIVS].quo})
                                 : $signed({2'b00, 17'(0), p_reg[DIVS].base})
                                   + $signed({2'b00, p_reg[DIVS].quo});
            if (!p_reg[DIVS].hit || p_reg[DIVS].status != plsc_pkg::ST_VALID)
                p_next[DIVS+1].norm = '0;
            else if (p_reg[DIVS].zero_span)
                p_next[DIVS+1].norm = p_reg[DIVS].base;
            else if (r2 < 0)
                p_next[DIVS+1].norm = '0;
            else if (r2 > $signed({2'b00, 17'(0), {NW{1'b1}}}))
                p_next[DIVS+1].norm = '1;
            else
                p_next[DIVS+1].norm = NW'(r2);
        end
        p_next[DIVS+2] = p_reg[DIVS+1];
        p_next[DIVS+2].dprod = 44'(p_reg[DIVS+1].norm) * 44'(depth_gain);
        p_next[DIVS+3] = p_reg[DIVS+2];
        begin
            logic [63:0] d;
            d = (64'(p_reg[DIVS+2].dprod) + HALF) >> FRAC_BITS;
            p_next[DIVS+3].depth = (d > 64'({plsc_pkg::DEPTH_W{1'b1}})) ? '1
                                 : plsc_pkg::DEPTH_W'(d);
        end
        p_next[DIVS+4] = p_reg[DIVS+3];
        p_next[DIVS+4].vprod = 47'(p_reg[DIVS+3].depth) * 47'(volume_gain);
        p_next[DIVS+5] = p_reg[DIVS+4];
        begin
            logic [63:0] v;
            v = ((64'(p_reg[DIVS+4].vprod) + HALF) >> FRAC_BITS) + 64'(OFFSET);
            if (p_reg[DIVS+4].status != plsc_pkg::ST_VALID) begin
                p_next[DIVS+5].vol = '0;
                p_next[DIVS+5].depth = '0;
            end else begin
                p_next[DIVS+5].vol = (v > 64'(32'hFFFF_FFFF)) ? '1 : 32'(v);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NST; k++) v_reg[k] <= 1'b0;
        end else begin
            if (go) begin
                v_reg[0] <= job_valid && job_ready;
                for (int k = 1; k < NST; k++) v_reg[k] <= v_reg[k-1];
            end
        end
        if (go) begin
            for (int k = 0; k < NST; k++) p_reg[k] <= p_next[k];
        end
    end

    assign out_valid  = v_reg[NST-1];
    assign out_status = p_reg[NST-1].status;
    assign out_norm   = p_reg[NST-1].norm;
    assign out_depth  = p_reg[NST-1].depth;
    assign out_vol    = p_reg[NST-1].vol;
endmodule

FILE: src/piecewise_linear_sensor_calibration.sv
// Three-point calibration: each 16-bit sample word yields one result word with
// status, normalized value, depth and volume. One word per cycle sustained while
// the result side keeps up; a sample word passes through the two-word front
// queue, one numerator stage, 34 stages of the one-bit-per-stage divider of the
// interpolation, one stage for the normalized value and two each for depth and
// volume. A result stall freezes the whole back pipeline; the front queue then
// fills and s_tready drops. Configure only while idle.
`include "assert_macros.svh"
module piecewise_linear_sensor_calibration #(
    parameter int NUM_POINTS = plsc_pkg::NUM_POINTS_DEF,
    parameter int FRAC_BITS  = plsc_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,  // sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [79:0]                       m_tdata,  // status, normalized, depth, volume
    input  logic                              cfg_we,
    input  logic [plsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [plsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    logic [plsc_pkg::ADC_W-1:0]   adc_reg  [3];
    logic [plsc_pkg::NORM_W-1:0]  norm_reg [3];
    logic [plsc_pkg::DGAIN_W-1:0] dgain_reg;
    logic [plsc_pkg::VGAIN_W-1:0] vgain_reg;
    logic job_valid, job_ready;
    plsc_pkg::job_t job;
    logic [1:0]  st;
    logic [16:0] nrm;
    logic [26:0] dep;
    logic [31:0] vol;
    logic st_ok, err_nonzero, vol_no_off;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adc_reg[0] <= 16'd10158; adc_reg[1] <= 16'd30307; adc_reg[2] <= 16'd50456;
            norm_reg[0] <= 17'd0; norm_reg[1] <= 17'd32768; norm_reg[2] <= 17'd65536;
            dgain_reg <= 26'd37383727;
            vgain_reg <= 20'd8041;
        end else if (cfg_we) begin
            case (plsc_pkg::reg_idx_t'(cfg_index))
                plsc_pkg::R_ADC0:  adc_reg[0] <= cfg_data[15:0];
                plsc_pkg::R_ADC1:  adc_reg[1] <= cfg_data[15:0];
                plsc_pkg::R_ADC2:  adc_reg[2] <= cfg_data[15:0];
                plsc_pkg::R_NRM0:  norm_reg[0] <= cfg_data[16:0];
                plsc_pkg::R_NRM1:  norm_reg[1] <= cfg_data[16:0];
                plsc_pkg::R_NRM2:  norm_reg[2] <= cfg_data[16:0];
                plsc_pkg::R_DGAIN: dgain_reg <= cfg_data;
                plsc_pkg::R_VGAIN: vgain_reg <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    plsc_front #(.NUM_POINTS(NUM_POINTS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .sample(s_tdata),
        .adc_pt(adc_reg), .norm_pt(norm_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    plsc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .depth_gain(dgain_reg), .volume_gain(vgain_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_status(st), .out_norm(nrm), .out_depth(dep), .out_vol(vol)
    );

    assign m_tdata = {2'b00, vol, dep, nrm, st};

    assign st_ok       = (st == plsc_pkg::ST_VALID);
    assign err_nonzero = m_tvalid && !st_ok && (nrm != '0 || vol != '0);
    assign vol_no_off  = m_tvalid && st_ok && (vol == '0);

    `ASSERT_NEVER(a_err_zero, aclk, aresetn, err_nonzero, "bad fields on error status")
    `ASSERT_NEVER(a_vol_off, aclk, aresetn, vol_no_off, "valid volume lacks offset")
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
endmodule
